/* design/f4dse_pkg.sv */
// ----------------------------------------------------------------------------
// f4dse_pkg
// Shared constants for the F4 DCT-coefficient embed/extract block.
// ----------------------------------------------------------------------------
package f4dse_pkg;

   localparam int DEF_COEF_WIDTH  = 12;
   localparam int DEF_COUNT_WIDTH = 24;

   localparam int MSG_WIDTH  = 8;
   localparam int BITS_WIDTH = 4;   // bits still pending, 0..8
   localparam int GATH_WIDTH = 3;   // bits gathered into the current byte

   // result flags above coefficient_out: bit_used, byte_out, byte_valid,
   // need_byte, done_res, overrun
   localparam int RSP_EXTRA_BITS = MSG_WIDTH + 5;

   // configuration register indexes
   localparam logic REG_MODE       = 1'b0;
   localparam logic REG_BYTE_TOTAL = 1'b1;

   // item kinds on req_tuser
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_COEF = 1'b1;

   // modes
   localparam logic MODE_EMBED   = 1'b0;
   localparam logic MODE_EXTRACT = 1'b1;

   function automatic int byte_round(input int n);
      return ((n + 7) / 8) * 8;
   endfunction

endpackage

/* design/f4_dct_stego_embed_extract.sv */
// ----------------------------------------------------------------------------
// f4_dct_stego_embed_extract
// F4 steganography on quantized DCT coefficients: embeds message bits by
// stepping coefficients toward zero, or extracts bits into bytes.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  req_    | in  | req_tvalid/req_tready  | tuser: action; tdata: byte, coef
//  rsp_    | out | rsp_tvalid/rsp_tready  | tdata: coef out and status flags
//  csr_    | in  | csr_valid/csr_ready    | csr_index, csr_data
//
//  One item per cycle while rsp_ is not stalled; items go through the input
//  register, then the result register. The per-item path is one add/compare
//  on the coefficient plus the byte-count compares. Synchronous reset clears
//  both valids and the progress state. A stalled rsp_ holds the result and
//  the input register, so req_tready drops only when both are full.
// ----------------------------------------------------------------------------
module f4_dct_stego_embed_extract
   import f4dse_pkg::*;
#(
   parameter int COEF_WIDTH  = DEF_COEF_WIDTH,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,  // action
   // message_byte, coefficient, zero pad
   input  logic [byte_round(MSG_WIDTH+COEF_WIDTH)-1:0] req_tdata,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // coefficient_out, bit_used, byte_out, byte_valid, need_byte, done_res,
   // overrun, zero pad
   output logic [byte_round(COEF_WIDTH+RSP_EXTRA_BITS)-1:0] rsp_tdata,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [COUNT_WIDTH-1:0] csr_data
);

   localparam int RSP_W = byte_round(COEF_WIDTH + RSP_EXTRA_BITS);

   // configuration
   logic                   mode_ff;
   logic [COUNT_WIDTH-1:0] byte_total_ff;

   // progress state
   logic [MSG_WIDTH-1:0]   held_byte_ff,      held_byte_in;
   logic [BITS_WIDTH-1:0]  bits_left_ff,      bits_left_in;
   logic [MSG_WIDTH-1:0]   gathered_byte_ff,  gathered_byte_in;
   logic [GATH_WIDTH-1:0]  gathered_bits_ff,  gathered_bits_in;
   logic [COUNT_WIDTH-1:0] bytes_finished_ff, bytes_finished_in;

   // input register
   logic                   s1_valid_ff;
   logic                   s1_action_ff;
   logic [MSG_WIDTH-1:0]   s1_byte_ff;
   logic [COEF_WIDTH-1:0]  s1_coef_ff;

   // result register
   logic                   out_valid_ff;
   logic [RSP_W-1:0]       out_data_ff, out_data_in;

   logic req_xfer, out_load, s1_go, csr_xfer;

   assign out_load   = !out_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && out_load;
   assign req_tready = !s1_valid_ff || out_load;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_xfer   = csr_valid;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // per-item work
   always_comb begin
      logic                   done_now, done_after;
      logic                   nonzero, positive, have, want;
      logic [COEF_WIDTH-1:0]  stepped, cout;
      logic                   used, bvalid, ovr, need;
      logic [MSG_WIDTH-1:0]   bout;
      logic [GATH_WIDTH-1:0]  want_idx;
      logic [MSG_WIDTH-1:0]   shifted;

      held_byte_in      = held_byte_ff;
      bits_left_in      = bits_left_ff;
      gathered_byte_in  = gathered_byte_ff;
      gathered_bits_in  = gathered_bits_ff;
      bytes_finished_in = bytes_finished_ff;

      done_now = bytes_finished_ff >= byte_total_ff;
      nonzero  = |s1_coef_ff;
      positive = !s1_coef_ff[COEF_WIDTH-1] && nonzero;
      have     = positive ? s1_coef_ff[0] : !s1_coef_ff[0];
      want_idx = GATH_WIDTH'(bits_left_ff - BITS_WIDTH'(1));
      want     = held_byte_ff[want_idx];
      stepped  = positive ? s1_coef_ff - COEF_WIDTH'(1) : s1_coef_ff + COEF_WIDTH'(1);
      shifted  = {gathered_byte_ff[MSG_WIDTH-2:0], have};

      cout   = '0;
      used   = 1'b0;
      bvalid = 1'b0;
      ovr    = 1'b0;
      bout   = '0;

      if (s1_action_ff == ACT_LOAD) begin
         if (mode_ff == MODE_EMBED && bits_left_ff == '0 && !done_now) begin
            held_byte_in = s1_byte_ff;
            bits_left_in = BITS_WIDTH'(MSG_WIDTH);
         end else begin
            ovr = 1'b1;
         end
      end else begin
         cout = s1_coef_ff;
         if (nonzero && !done_now) begin
            if (mode_ff == MODE_EMBED) begin
               if (bits_left_ff != '0) begin
                  if (want != have) cout = stepped;
                  // shrunk to zero: bit retried on the next coefficient
                  if (cout != '0) begin
                     used         = 1'b1;
                     bits_left_in = bits_left_ff - BITS_WIDTH'(1);
                     if (bits_left_in == '0)
                        bytes_finished_in = bytes_finished_ff + COUNT_WIDTH'(1);
                  end
               end
            end else begin
               used = 1'b1;
               if (gathered_bits_ff == '1) begin
                  bout              = shifted;
                  bvalid            = 1'b1;
                  gathered_byte_in  = '0;
                  gathered_bits_in  = '0;
                  bytes_finished_in = bytes_finished_ff + COUNT_WIDTH'(1);
               end else begin
                  gathered_byte_in = shifted;
                  gathered_bits_in = gathered_bits_ff + GATH_WIDTH'(1);
               end
            end
         end
      end

      done_after = bytes_finished_in >= byte_total_ff;
      need = (mode_ff == MODE_EMBED) && (bits_left_in == '0) && !done_after;

      out_data_in = RSP_W'({ovr, done_after, need, bvalid, bout, used, cout});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_EMBED;
         byte_total_ff     <= '0;
         held_byte_ff      <= '0;
         bits_left_ff      <= '0;
         gathered_byte_ff  <= '0;
         gathered_bits_ff  <= '0;
         bytes_finished_ff <= '0;
         s1_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
      end else begin
         if (csr_xfer) begin
            case (csr_index)
               REG_MODE:       mode_ff       <= csr_data[0];
               REG_BYTE_TOTAL: byte_total_ff <= csr_data;
               default:        ;
            endcase
         end
         if (s1_go) begin
            held_byte_ff      <= held_byte_in;
            bits_left_ff      <= bits_left_in;
            gathered_byte_ff  <= gathered_byte_in;
            gathered_bits_ff  <= gathered_bits_in;
            bytes_finished_ff <= bytes_finished_in;
         end
         if (req_xfer)       s1_valid_ff <= 1'b1;
         else if (s1_go)     s1_valid_ff <= 1'b0;
         if (s1_go)          out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_action_ff <= req_tuser;
         s1_byte_ff   <= req_tdata[MSG_WIDTH-1:0];
         s1_coef_ff   <= req_tdata[MSG_WIDTH +: COEF_WIDTH];
      end
      if (s1_go) out_data_ff <= out_data_in;
   end

endmodule

/* design/f4dse_checker.sv */
// ----------------------------------------------------------------------------
// f4dse_checker
// Port-level checks on the result stream of the embed/extract block.
// ----------------------------------------------------------------------------
module f4dse_checker
   import f4dse_pkg::*;
#(
   parameter int COEF_WIDTH = DEF_COEF_WIDTH
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [byte_round(COEF_WIDTH+RSP_EXTRA_BITS)-1:0] rsp_tdata
);

   logic                  bit_used, byte_valid, need_byte, done_res, overrun;
   logic [COEF_WIDTH-1:0] coef_out;

   assign coef_out   = rsp_tdata[COEF_WIDTH-1:0];
   assign bit_used   = rsp_tdata[COEF_WIDTH];
   assign byte_valid = rsp_tdata[COEF_WIDTH+MSG_WIDTH+1];
   assign need_byte  = rsp_tdata[COEF_WIDTH+MSG_WIDTH+2];
   assign done_res   = rsp_tdata[COEF_WIDTH+MSG_WIDTH+3];
   assign overrun    = rsp_tdata[COEF_WIDTH+MSG_WIDTH+4];

   // stalled transfer keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp payload changed while stalled");

   a_byte_used: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && byte_valid |-> bit_used && !need_byte)
      else $error("byte completed without a carried bit");

   a_need_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(need_byte && done_res))
      else $error("need_byte while run is done");

   a_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && overrun |-> !bit_used && !byte_valid && coef_out == '0)
      else $error("ignored load produced coefficient data");

endmodule

bind f4_dct_stego_embed_extract f4dse_checker #(
   .COEF_WIDTH(COEF_WIDTH)
) u_f4dse_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
